// File: rtl/core/edfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfs_pkg
// Shared types and constants for the periodic task scheduler: task slot
// count, field widths, register map and the per-tick result record.
// ----------------------------------------------------------------------------
package edfs_pkg;

   // Register slots in the map, and tasks actually scheduled (1..SLOTS)
   localparam int SLOTS      = 4;
   localparam int TASKS      = 4;
   localparam int SLOT_IDX_W = $clog2(SLOTS);
   localparam int TASK_IDX_W = 2;

   // Field widths
   localparam int WORK_W     = 8;
   localparam int TIME_W     = 16;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

   // Register map: execution times first, then periods
   localparam int REG_EXEC_BASE   = 0;
   localparam int REG_PERIOD_BASE = SLOTS;

   typedef logic [WORK_W-1:0]     work_type;
   typedef logic [TIME_W-1:0]     time_type;
   typedef logic [TASK_IDX_W-1:0] task_idx_type;

   typedef work_type [SLOTS-1:0]  slot_regs_type;

   // Result of one tick
   typedef struct packed {
      time_type     tick_time;
      logic         switched;
      logic         idle;
      task_idx_type running_task;
   } result_type;

endpackage

// File: rtl/core/edfs_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfs_csr
// Configuration register file: execution time and period of each task slot.
// Writes to indexes outside the map are accepted and dropped.
// ----------------------------------------------------------------------------
module edfs_csr
   import edfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output slot_regs_type         exec_time,
   output slot_regs_type         period
);

   slot_regs_type exec_time_ff, exec_time_in;
   slot_regs_type period_ff, period_in;
   logic          wr_en;

   // Always able to take a write transaction
   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // Decode the index against each slot
   always_comb begin
      exec_time_in = exec_time_ff;
      period_in    = period_ff;
      for (int k = 0; k < SLOTS; k++) begin
         if (wr_en && csr_index == CSR_ADDR_W'(REG_EXEC_BASE + k)) begin
            exec_time_in[k] = csr_data[WORK_W-1:0];
         end
         if (wr_en && csr_index == CSR_ADDR_W'(REG_PERIOD_BASE + k)) begin
            period_in[k] = csr_data[WORK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) begin
            exec_time_ff[k] <= work_type'(1);
            period_ff[k]    <= '0;
         end
      end else begin
         exec_time_ff <= exec_time_in;
         period_ff    <= period_in;
      end
   end

   assign exec_time = exec_time_ff;
   assign period    = period_ff;

endmodule

// File: rtl/core/edfs_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfs_sched
// Task state and one-tick scheduling pass: release expired tasks, pick the
// ready task with the nearest next release, retire one tick of its work
// and step the countdowns and time base.
// ----------------------------------------------------------------------------
module edfs_sched
   import edfs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          tick,
   input  logic          restart,
   input  slot_regs_type exec_time,
   input  slot_regs_type period,
   output result_type    result
);

   work_type [TASKS-1:0] rem_ff, rem_in;
   work_type [TASKS-1:0] cd_ff, cd_in;
   logic     [TASKS-1:0] rdy_ff, rdy_in;
   logic                 prev_idle_ff, prev_idle_in;
   task_idx_type         prev_idx_ff, prev_idx_in;
   time_type             time_ff, time_in;

   // Next-state and result logic for one tick
   always_comb begin
      work_type [TASKS-1:0] rem;
      work_type [TASKS-1:0] cd;
      logic     [TASKS-1:0] rdy;
      logic                 prev_idle;
      task_idx_type         prev_idx;
      time_type             now;
      logic                 found;
      task_idx_type         pick;
      work_type             best;

      // Restart clears run state before the tick
      rem       = restart ? '0 : rem_ff;
      cd        = restart ? '0 : cd_ff;
      rdy       = restart ? '0 : rdy_ff;
      prev_idle = restart ? 1'b1 : prev_idle_ff;
      prev_idx  = prev_idx_ff;
      now       = restart ? '0 : time_ff;

      // Release expired tasks, drop disabled ones
      for (int k = 0; k < TASKS; k++) begin
         if (period[k] == '0) begin
            rdy[k] = 1'b0;
            rem[k] = '0;
            cd[k]  = '0;
         end else if (cd[k] == '0) begin
            if (!rdy[k]) begin
               rem[k] = (exec_time[k] == '0) ? work_type'(1) : exec_time[k];
               rdy[k] = 1'b1;
            end
            cd[k] = period[k];
         end
      end

      // Nearest release wins, lower index on ties
      found = 1'b0;
      pick  = '0;
      best  = '0;
      for (int k = 0; k < TASKS; k++) begin
         if (rdy[k] && (!found || cd[k] < best)) begin
            found = 1'b1;
            pick  = task_idx_type'(k);
            best  = cd[k];
         end
      end

      result.running_task = pick;
      result.idle         = !found;
      result.switched     = (found == prev_idle) || (found && pick != prev_idx);
      result.tick_time    = now;

      // Retire one tick of work on the chosen task
      for (int k = 0; k < TASKS; k++) begin
         if (found && pick == task_idx_type'(k)) begin
            if (rem[k] <= work_type'(1)) begin
               rem[k] = '0;
               rdy[k] = 1'b0;
            end else begin
               rem[k] = rem[k] - work_type'(1);
            end
         end
      end

      // Step countdowns of enabled tasks
      for (int k = 0; k < TASKS; k++) begin
         if (period[k] != '0 && cd[k] != '0) begin
            cd[k] = cd[k] - work_type'(1);
         end
      end

      // Hold unless a tick transaction is taken
      rem_in       = tick ? rem : rem_ff;
      cd_in        = tick ? cd : cd_ff;
      rdy_in       = tick ? rdy : rdy_ff;
      prev_idle_in = tick ? !found : prev_idle_ff;
      prev_idx_in  = tick ? pick : prev_idx;
      time_in      = tick ? now + time_type'(1) : time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         cd_ff        <= '0;
         rdy_ff       <= '0;
         prev_idle_ff <= 1'b1;
         prev_idx_ff  <= '0;
         time_ff      <= '0;
      end else begin
         rem_ff       <= rem_in;
         cd_ff        <= cd_in;
         rdy_ff       <= rdy_in;
         prev_idle_ff <= prev_idle_in;
         prev_idx_ff  <= prev_idx_in;
         time_ff      <= time_in;
      end
   end

endmodule

// File: rtl/core/edfs_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfs_out_reg
// Result register on the output stream. Loads a new result in the same
// cycle the held one is taken; one tick per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
module edfs_out_reg
   import edfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  result_type             result,
   output logic                   space,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Room when empty or when the held result leaves this cycle
   assign space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = load || (valid_ff && !rsp_tready);
      data_in  = load ? result : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(data_ff);

endmodule

// File: rtl/core/edf_periodic_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler
// Earliest-deadline-first scheduler for periodic tasks. Each request
// transaction is one time tick; each tick yields one response transaction.
//
//   Channel   Direction  Carries
//   req_      in         tick, restart flag
//   rsp_      out        running task, idle, switched, tick time
//   csr_      in         register index and data (exec times, periods)
//
// One tick per cycle unless rsp_ stalls; a tick is scheduled in the cycle it is
// taken and its result appears on rsp_ in the next cycle. The scheduling pass
// (release, four-way nearest-deadline pick, work and countdown update) sets the path.
// Reset clears task state and loads exec time 1, period 0 in all slots.
// A stalled rsp_ holds req_tready low only while its result register is full.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler
   import edfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Tick input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [0] restart
   // Tick result
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [1:0] running_task, [2] idle,
                                               // [3] switched, [19:4] tick_time
   // Register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_ADDR_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   slot_regs_type exec_time;
   slot_regs_type period;
   result_type    result;
   logic          space;
   logic          tick;

   // Take a tick whenever the result register has room
   assign req_tready = space;
   assign tick       = req_tvalid & req_tready;

   edfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .exec_time (exec_time),
      .period    (period)
   );

   edfs_sched u_sched (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .restart   (req_tdata[0]),
      .exec_time (exec_time),
      .period    (period),
      .result    (result)
   );

   edfs_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (tick),
      .result     (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
